FILE: rtl/cmm_pkg.sv
package cmm_pkg;

   localparam int MAX_N     = 8;
   localparam int DATA_BITS = 16;
   localparam int IDX_BITS  = 3;
   localparam int ADDR_BITS = 2 * IDX_BITS;
   localparam int CELLS     = MAX_N * MAX_N;
   localparam int ELEM_BITS = 2 * DATA_BITS;
   localparam int PROD_BITS = 2 * DATA_BITS;
   localparam int OUT_BITS  = 36;
   localparam int SIZE_BITS = 4;
   localparam int MODE_BITS = 3;
   localparam int FUNC_BITS = 2;
   localparam int CSR_IDX_BITS = 1;

   localparam int CMD_DEPTH    = 2;
   localparam int CMD_PTR_BITS = 1;
   localparam int CMD_CNT_BITS = 2;

   localparam int OUT_DEPTH    = 4;
   localparam int OUT_PTR_BITS = 2;
   localparam int OUT_CNT_BITS = 3;

   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_A  = 2'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOAD_B  = 2'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_COMPUTE = 2'd2;

   localparam logic [MODE_BITS-1:0] MODE_A_B  = 3'd0;
   localparam logic [MODE_BITS-1:0] MODE_AT_B = 3'd1;
   localparam logic [MODE_BITS-1:0] MODE_AH_B = 3'd2;
   localparam logic [MODE_BITS-1:0] MODE_A_BT = 3'd3;
   localparam logic [MODE_BITS-1:0] MODE_A_BH = 3'd4;

   localparam logic [CSR_IDX_BITS-1:0] REG_SIZE = 1'b0;
   localparam logic [CSR_IDX_BITS-1:0] REG_MODE = 1'b1;

   typedef struct packed {
      logic                        is_compute;
      logic                        sel_b;
      logic [IDX_BITS-1:0]         row;
      logic [IDX_BITS-1:0]         col;
      logic signed [DATA_BITS-1:0] re;
      logic signed [DATA_BITS-1:0] im;
   } cmd_type;

   typedef struct packed {
      logic [SIZE_BITS-1:0] n;
      logic                 trans_a;
      logic                 trans_b;
      logic                 conj_a;
      logic                 conj_b;
   } op_cfg_type;

   typedef struct packed {
      logic                first;
      logic                lastk;
      logic                last_elem;
      logic [IDX_BITS-1:0] i;
      logic [IDX_BITS-1:0] j;
   } tag_type;

   typedef struct packed {
      logic [IDX_BITS-1:0]        row;
      logic [IDX_BITS-1:0]        col;
      logic signed [OUT_BITS-1:0] re;
      logic signed [OUT_BITS-1:0] im;
      logic                       last;
   } result_type;

endpackage

FILE: rtl/complex_matrix_multiply_top.sv
// Complex matrix multiply, C = op(A) * op(B), N x N with N up to 8.
//
// Request channel (req_*): one transfer per item. func selects load A,
// load B (element at row/col, Q1.15 parts) or compute. Transfers with func 3
// are dropped. A load transfer makes no response.
// Response channel (rsp_*): a compute emits N*N transfers of C in
// row-major order, Q6.30 exact sums, rsp_last high on the final one.
// CSR channel (csr_*): index 0 = matrix size, 1 = mode. Always ready;
// write only while the block is idle.
//
// Rate: a load occupies the back end only while it is written. A compute
// runs one complex MAC per cycle, while a result slot can be reserved for
// each new element, through the shared multiplier pipeline (RAM read,
// products, terms, accumulate).
// A two-entry command queue lets requests land while a compute runs;
// req_stall rises only when it is full.
// Stalling rsp_stall fills a four-entry result queue; once all its slots are
// reserved the MAC sequencer holds at the next element boundary, nothing is lost.
// Reset: queues empty, size 8, mode 0. Matrix RAM contents are not
// cleared; load every element used before computing.
module complex_matrix_multiply_top (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     req_valid,
   output logic                                     req_stall,
   input  logic [cmm_pkg::FUNC_BITS-1:0]            req_func,
   input  logic [cmm_pkg::IDX_BITS-1:0]             req_row,
   input  logic [cmm_pkg::IDX_BITS-1:0]             req_col,
   input  logic signed [cmm_pkg::DATA_BITS-1:0]     req_data_re,
   input  logic signed [cmm_pkg::DATA_BITS-1:0]     req_data_im,
   output logic                                     rsp_valid,
   input  logic                                     rsp_stall,
   output logic [cmm_pkg::IDX_BITS-1:0]             rsp_out_row,
   output logic [cmm_pkg::IDX_BITS-1:0]             rsp_out_col,
   output logic signed [cmm_pkg::OUT_BITS-1:0]      rsp_out_re,
   output logic signed [cmm_pkg::OUT_BITS-1:0]      rsp_out_im,
   output logic                                     rsp_last,
   input  logic                                     csr_valid,
   output logic                                     csr_ready,
   input  logic [cmm_pkg::CSR_IDX_BITS-1:0]         csr_index,
   input  logic [cmm_pkg::SIZE_BITS-1:0]            csr_data
);

   logic [cmm_pkg::SIZE_BITS-1:0]  size_ff;
   logic [cmm_pkg::MODE_BITS-1:0]  mode_ff;
   cmm_pkg::op_cfg_type            cfg;
   logic                           cmd_valid;
   cmm_pkg::cmd_type               cmd;
   logic                           cmd_pop;

   assign csr_ready = 1'b1;

   // config registers; an accepted transfer is registered
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff <= cmm_pkg::SIZE_BITS'(cmm_pkg::MAX_N);
         mode_ff <= cmm_pkg::MODE_A_B;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            cmm_pkg::REG_SIZE: size_ff <= csr_data;
            cmm_pkg::REG_MODE: mode_ff <= csr_data[cmm_pkg::MODE_BITS-1:0];
            default:           size_ff <= size_ff;
         endcase
      end
   end

   // size clamps to 1..MAX_N; unknown modes behave as plain A*B
   always_comb begin
      if (size_ff == '0) begin
         cfg.n = cmm_pkg::SIZE_BITS'(1);
      end else if (size_ff > cmm_pkg::SIZE_BITS'(cmm_pkg::MAX_N)) begin
         cfg.n = cmm_pkg::SIZE_BITS'(cmm_pkg::MAX_N);
      end else begin
         cfg.n = size_ff;
      end
      cfg.trans_a = 1'b0;
      cfg.trans_b = 1'b0;
      cfg.conj_a  = 1'b0;
      cfg.conj_b  = 1'b0;
      unique case (mode_ff)
         cmm_pkg::MODE_AT_B: cfg.trans_a = 1'b1;
         cmm_pkg::MODE_AH_B: begin
            cfg.trans_a = 1'b1;
            cfg.conj_a  = 1'b1;
         end
         cmm_pkg::MODE_A_BT: cfg.trans_b = 1'b1;
         cmm_pkg::MODE_A_BH: begin
            cfg.trans_b = 1'b1;
            cfg.conj_b  = 1'b1;
         end
         default: cfg.trans_a = 1'b0;
      endcase
   end

   cmm_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_func    (req_func),
      .req_row     (req_row),
      .req_col     (req_col),
      .req_data_re (req_data_re),
      .req_data_im (req_data_im),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   cmm_back u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_out_row (rsp_out_row),
      .rsp_out_col (rsp_out_col),
      .rsp_out_re  (rsp_out_re),
      .rsp_out_im  (rsp_out_im),
      .rsp_last    (rsp_last)
   );

endmodule

FILE: rtl/cmm_ram.sv
module cmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/cmm_front.sv
module cmm_front (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic [cmm_pkg::FUNC_BITS-1:0]         req_func,
   input  logic [cmm_pkg::IDX_BITS-1:0]          req_row,
   input  logic [cmm_pkg::IDX_BITS-1:0]          req_col,
   input  logic signed [cmm_pkg::DATA_BITS-1:0]  req_data_re,
   input  logic signed [cmm_pkg::DATA_BITS-1:0]  req_data_im,
   output logic                                  cmd_valid,
   output cmm_pkg::cmd_type                      cmd,
   input  logic                                  cmd_pop
);

   cmm_pkg::cmd_type                      q_ff [cmm_pkg::CMD_DEPTH];
   logic [cmm_pkg::CMD_PTR_BITS-1:0]      wr_ptr_ff, wr_ptr_in;
   logic [cmm_pkg::CMD_PTR_BITS-1:0]      rd_ptr_ff, rd_ptr_in;
   logic [cmm_pkg::CMD_CNT_BITS-1:0]      count_ff, count_in;
   logic                                  in_range;
   logic                                  keep;
   logic                                  push;
   cmm_pkg::cmd_type                      new_cmd;

   // classify: loads outside the array and unknown funcs are dropped here
   always_comb begin
      in_range = (cmm_pkg::SIZE_BITS'(req_row) < cmm_pkg::SIZE_BITS'(cmm_pkg::MAX_N)) &&
                 (cmm_pkg::SIZE_BITS'(req_col) < cmm_pkg::SIZE_BITS'(cmm_pkg::MAX_N));
      unique case (req_func) inside
         cmm_pkg::FUNC_LOAD_A, cmm_pkg::FUNC_LOAD_B: keep = in_range;
         cmm_pkg::FUNC_COMPUTE:                      keep = 1'b1;
         default:                                    keep = 1'b0;
      endcase
      new_cmd.is_compute = (req_func == cmm_pkg::FUNC_COMPUTE);
      new_cmd.sel_b      = (req_func == cmm_pkg::FUNC_LOAD_B);
      new_cmd.row        = req_row;
      new_cmd.col        = req_col;
      new_cmd.re         = req_data_re;
      new_cmd.im         = req_data_im;
   end

   assign req_stall = (count_ff == cmm_pkg::CMD_CNT_BITS'(cmm_pkg::CMD_DEPTH));
   assign push      = req_valid && !req_stall && keep;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = q_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push    ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = cmd_pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff + cmm_pkg::CMD_CNT_BITS'(push) - cmm_pkg::CMD_CNT_BITS'(cmd_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= new_cmd;
      end
   end

endmodule

FILE: rtl/cmm_back.sv
module cmm_back (
   input  logic                                  clock,
   input  logic                                  reset,
   input  cmm_pkg::op_cfg_type                   cfg,
   input  logic                                  cmd_valid,
   input  cmm_pkg::cmd_type                      cmd,
   output logic                                  cmd_pop,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic [cmm_pkg::IDX_BITS-1:0]          rsp_out_row,
   output logic [cmm_pkg::IDX_BITS-1:0]          rsp_out_col,
   output logic signed [cmm_pkg::OUT_BITS-1:0]   rsp_out_re,
   output logic signed [cmm_pkg::OUT_BITS-1:0]   rsp_out_im,
   output logic                                  rsp_last
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic                                  state_ff, state_in;
   logic [cmm_pkg::IDX_BITS-1:0]          i_ff, i_in, j_ff, j_in, k_ff, k_in;
   logic [cmm_pkg::SIZE_BITS-1:0]         n_m1;
   logic                                  k_last, j_last, i_last;
   logic                                  issue, start;

   logic                                  wr_a, wr_b;
   logic [cmm_pkg::ADDR_BITS-1:0]         wr_addr, rd_addr_a, rd_addr_b;
   logic [cmm_pkg::ELEM_BITS-1:0]         wr_data, rd_data_a, rd_data_b;

   logic                                  s1_valid_ff, s2_valid_ff, s3_valid_ff;
   cmm_pkg::tag_type                      s1_tag_ff, s1_tag_in, s2_tag_ff, s3_tag_ff;

   logic signed [cmm_pkg::DATA_BITS-1:0]  a_re, a_im, b_re, b_im;
   logic signed [cmm_pkg::PROD_BITS-1:0]  p_rr_ff, p_ii_ff, p_ri_ff, p_ir_ff;
   logic signed [cmm_pkg::OUT_BITS-1:0]   t_re_ff, t_re_in, t_im_ff, t_im_in;
   logic signed [cmm_pkg::OUT_BITS-1:0]   acc_re_ff, acc_re_in, acc_im_ff, acc_im_in;

   cmm_pkg::result_type                   out_ff [cmm_pkg::OUT_DEPTH];
   cmm_pkg::result_type                   new_res;
   logic [cmm_pkg::OUT_PTR_BITS-1:0]      head_ff, head_in, tail_ff, tail_in;
   logic [cmm_pkg::OUT_CNT_BITS-1:0]      count_ff, count_in, reserved_ff, reserved_in;
   logic                                  push, pop;

   // ---------------- sequencer ----------------
   always_comb begin
      n_m1   = cfg.n - 1'b1;
      k_last = (cmm_pkg::SIZE_BITS'(k_ff) == n_m1);
      j_last = (cmm_pkg::SIZE_BITS'(j_ff) == n_m1);
      i_last = (cmm_pkg::SIZE_BITS'(i_ff) == n_m1);
      // an element starts only with a result slot reserved for it
      issue  = (state_ff == ST_RUN) &&
               ((k_ff != '0) || (reserved_ff < cmm_pkg::OUT_CNT_BITS'(cmm_pkg::OUT_DEPTH)));
      start  = issue && (k_ff == '0);

      state_in = state_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      cmd_pop  = 1'b0;
      wr_a     = 1'b0;
      wr_b     = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop = 1'b1;
               if (cmd.is_compute) begin
                  state_in = ST_RUN;
                  i_in     = '0;
                  j_in     = '0;
                  k_in     = '0;
               end else begin
                  wr_a = !cmd.sel_b;
                  wr_b = cmd.sel_b;
               end
            end
         end
         ST_RUN: begin
            if (issue) begin
               if (k_last) begin
                  k_in = '0;
                  if (j_last) begin
                     j_in = '0;
                     if (i_last) begin
                        i_in     = '0;
                        state_in = ST_IDLE;
                     end else begin
                        i_in = i_ff + 1'b1;
                     end
                  end else begin
                     j_in = j_ff + 1'b1;
                  end
               end else begin
                  k_in = k_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase

      wr_addr   = {cmd.row, cmd.col};
      wr_data   = {cmd.re, cmd.im};
      rd_addr_a = cfg.trans_a ? {k_ff, i_ff} : {i_ff, k_ff};
      rd_addr_b = cfg.trans_b ? {j_ff, k_ff} : {k_ff, j_ff};

      s1_tag_in.first     = (k_ff == '0);
      s1_tag_in.lastk     = k_last;
      s1_tag_in.last_elem = i_last && j_last;
      s1_tag_in.i         = i_ff;
      s1_tag_in.j         = j_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   cmm_ram #(
      .WIDTH (cmm_pkg::ELEM_BITS),
      .DEPTH (cmm_pkg::CELLS)
   ) u_ram_a (
      .clock   (clock),
      .wr_en   (wr_a),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_a),
      .rd_data (rd_data_a)
   );

   cmm_ram #(
      .WIDTH (cmm_pkg::ELEM_BITS),
      .DEPTH (cmm_pkg::CELLS)
   ) u_ram_b (
      .clock   (clock),
      .wr_en   (wr_b),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr_b),
      .rd_data (rd_data_b)
   );

   // ---------------- MAC pipeline ----------------
   always_comb begin
      a_re = rd_data_a[cmm_pkg::ELEM_BITS-1:cmm_pkg::DATA_BITS];
      a_im = rd_data_a[cmm_pkg::DATA_BITS-1:0];
      b_re = rd_data_b[cmm_pkg::ELEM_BITS-1:cmm_pkg::DATA_BITS];
      b_im = rd_data_b[cmm_pkg::DATA_BITS-1:0];

      // conjugation folds into the signs of the p_ii term and the cross terms
      if (cfg.conj_a || cfg.conj_b) begin
         t_re_in = cmm_pkg::OUT_BITS'(p_rr_ff) + cmm_pkg::OUT_BITS'(p_ii_ff);
      end else begin
         t_re_in = cmm_pkg::OUT_BITS'(p_rr_ff) - cmm_pkg::OUT_BITS'(p_ii_ff);
      end
      if (cfg.conj_a) begin
         t_im_in = cmm_pkg::OUT_BITS'(p_ri_ff) - cmm_pkg::OUT_BITS'(p_ir_ff);
      end else if (cfg.conj_b) begin
         t_im_in = cmm_pkg::OUT_BITS'(p_ir_ff) - cmm_pkg::OUT_BITS'(p_ri_ff);
      end else begin
         t_im_in = cmm_pkg::OUT_BITS'(p_ri_ff) + cmm_pkg::OUT_BITS'(p_ir_ff);
      end

      acc_re_in = (s3_tag_ff.first ? '0 : acc_re_ff) + t_re_ff;
      acc_im_in = (s3_tag_ff.first ? '0 : acc_im_ff) + t_im_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= issue;
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      s1_tag_ff <= s1_tag_in;
      s2_tag_ff <= s1_tag_ff;
      s3_tag_ff <= s2_tag_ff;
      p_rr_ff   <= a_re * b_re;
      p_ii_ff   <= a_im * b_im;
      p_ri_ff   <= a_re * b_im;
      p_ir_ff   <= a_im * b_re;
      t_re_ff   <= t_re_in;
      t_im_ff   <= t_im_in;
      if (s3_valid_ff) begin
         acc_re_ff <= acc_re_in;
         acc_im_ff <= acc_im_in;
      end
   end

   // ---------------- result queue ----------------
   always_comb begin
      push         = s3_valid_ff && s3_tag_ff.lastk;
      pop          = rsp_valid && !rsp_stall;
      new_res.row  = s3_tag_ff.i;
      new_res.col  = s3_tag_ff.j;
      new_res.re   = acc_re_in;
      new_res.im   = acc_im_in;
      new_res.last = s3_tag_ff.last_elem;
      head_in      = pop  ? head_ff + 1'b1 : head_ff;
      tail_in      = push ? tail_ff + 1'b1 : tail_ff;
      count_in     = count_ff + cmm_pkg::OUT_CNT_BITS'(push)
                     - cmm_pkg::OUT_CNT_BITS'(pop);
      reserved_in  = reserved_ff + cmm_pkg::OUT_CNT_BITS'(start)
                     - cmm_pkg::OUT_CNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         count_ff    <= '0;
         reserved_ff <= '0;
      end else begin
         head_ff     <= head_in;
         tail_ff     <= tail_in;
         count_ff    <= count_in;
         reserved_ff <= reserved_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         out_ff[tail_ff] <= new_res;
      end
   end

   assign rsp_valid   = (count_ff != '0);
   assign rsp_out_row = out_ff[head_ff].row;
   assign rsp_out_col = out_ff[head_ff].col;
   assign rsp_out_re  = out_ff[head_ff].re;
   assign rsp_out_im  = out_ff[head_ff].im;
   assign rsp_last    = out_ff[head_ff].last;

endmodule
